FILE: src/b2d_pkg.sv
package b2d_pkg;

   localparam int unsigned VALUE_W        = 64;
   localparam int unsigned CHAR_W         = 8;
   localparam int unsigned BIT_CNT_W      = $clog2(VALUE_W);
   localparam int unsigned DEF_MAX_DIGITS = 20;

   localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'd48;
   localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'd57;
   localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'd45;

   // Double-dabble correction: a BCD digit of five or more gets three added before a shift.
   localparam logic [3:0] DIGIT_ADJ_MIN = 4'd5;
   localparam logic [3:0] DIGIT_ADJ     = 4'd3;

   // Microprogram step addresses.
   typedef logic [2:0] step_type;
   localparam step_type STEP_IDLE  = 3'd0;
   localparam step_type STEP_SHIFT = 3'd1;
   localparam step_type STEP_SCAN  = 3'd2;
   localparam step_type STEP_SIGN  = 3'd3;
   localparam step_type STEP_DIGIT = 3'd4;

   // Jump conditions evaluated by the sequencer.
   typedef enum logic [2:0] {
      COND_ACCEPT    = 3'd0,
      COND_BITS_DONE = 3'd1,
      COND_SCAN_DONE = 3'd2,
      COND_SIGN_DONE = 3'd3,
      COND_LAST_DONE = 3'd4
   } cond_type;

   // Datapath enables carried in each control word.
   typedef struct packed {
      logic accept_en;
      logic shift_en;
      logic scan_en;
      logic sign_en;
      logic digit_en;
   } ctrl_type;

   // Status flags returned from the datapath to the sequencer.
   typedef struct packed {
      logic accept;
      logic bits_done;
      logic scan_done;
      logic sign_done;
      logic last_done;
   } stat_type;

endpackage

FILE: src/b2d_if.sv
interface b2d_req_if;
   logic                                valid;
   logic                                ready;
   logic signed [b2d_pkg::VALUE_W-1:0]  value;

   modport source (output valid, output value, input ready);
   modport sink   (input valid, input value, output ready);
endinterface

interface b2d_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [b2d_pkg::CHAR_W-1:0]  text_char;
   logic                        last_char;

   modport source (output valid, output text_char, output last_char, input ready);
   modport sink   (input valid, input text_char, input last_char, output ready);
endinterface

FILE: src/b2d_ucode.sv
module b2d_ucode (
   input  logic               clock,
   input  logic               reset,
   input  b2d_pkg::stat_type  stat,
   output b2d_pkg::ctrl_type  ctrl
);
   import b2d_pkg::*;

   typedef struct packed {
      ctrl_type ctrl;
      cond_type cond;
      step_type target;
   } uword_type;

   // The microprogram. Each step holds until its condition is true, then jumps.
   function automatic uword_type ucode_rom(input step_type addr);
      uword_type w;
      begin
         w = '{ctrl: '0, cond: COND_ACCEPT, target: STEP_IDLE};
         unique case (addr)
            STEP_IDLE: begin
               w.ctrl.accept_en = 1'b1;
               w.cond           = COND_ACCEPT;
               w.target         = STEP_SHIFT;
            end
            STEP_SHIFT: begin
               w.ctrl.shift_en = 1'b1;
               w.cond          = COND_BITS_DONE;
               w.target        = STEP_SCAN;
            end
            STEP_SCAN: begin
               w.ctrl.scan_en = 1'b1;
               w.cond         = COND_SCAN_DONE;
               w.target       = STEP_SIGN;
            end
            STEP_SIGN: begin
               w.ctrl.sign_en = 1'b1;
               w.cond         = COND_SIGN_DONE;
               w.target       = STEP_DIGIT;
            end
            STEP_DIGIT: begin
               w.ctrl.digit_en = 1'b1;
               w.cond          = COND_LAST_DONE;
               w.target        = STEP_IDLE;
            end
            default: begin
               w.cond   = COND_BITS_DONE;
               w.target = STEP_IDLE;
            end
         endcase
         return w;
      end
   endfunction

   step_type  pc_ff;
   step_type  pc_in;
   uword_type word;
   logic      cond_true;

   assign word = ucode_rom(pc_ff);
   assign ctrl = word.ctrl;

   always_comb begin
      unique case (word.cond)
         COND_ACCEPT:    cond_true = stat.accept;
         COND_BITS_DONE: cond_true = stat.bits_done;
         COND_SCAN_DONE: cond_true = stat.scan_done;
         COND_SIGN_DONE: cond_true = stat.sign_done;
         COND_LAST_DONE: cond_true = stat.last_done;
         default:        cond_true = 1'b1;
      endcase
      pc_in = cond_true ? word.target : pc_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= STEP_IDLE;
      end else begin
         pc_ff <= pc_in;
      end
   end

endmodule

FILE: src/b2d_datapath.sv
module b2d_datapath #(
   parameter int unsigned MAX_DIGITS = b2d_pkg::DEF_MAX_DIGITS
) (
   input  logic               clock,
   input  logic               reset,
   input  b2d_pkg::ctrl_type  ctrl,
   output b2d_pkg::stat_type  stat,
   b2d_req_if.sink            req_ch,
   b2d_rsp_if.source          rsp_ch
);
   import b2d_pkg::*;

   localparam int unsigned IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
   localparam logic [IDX_W-1:0] TOP_IDX = IDX_W'(MAX_DIGITS - 1);

   logic [VALUE_W-1:0]   mag_ff, mag_in;
   logic                 neg_ff, neg_in;
   logic [BIT_CNT_W-1:0] bitcnt_ff, bitcnt_in;
   logic [3:0]           bcd_ff [MAX_DIGITS];
   logic [3:0]           bcd_in [MAX_DIGITS];
   logic [3:0]           adj    [MAX_DIGITS];
   logic                 sticky_ff, sticky_in;
   logic [IDX_W-1:0]     idx_ff, idx_in;
   logic                 out_valid_ff, out_valid_in;
   logic [CHAR_W-1:0]    out_char_ff, out_char_in;
   logic                 out_last_ff, out_last_in;

   logic                 accept;
   logic                 out_free;
   logic [3:0]           cur_digit;
   logic                 idx_zero;
   logic [VALUE_W-1:0]   raw;

   assign req_ch.ready     = ctrl.accept_en;
   assign accept           = req_ch.valid && ctrl.accept_en;
   assign raw              = $unsigned(req_ch.value);
   assign out_free         = !out_valid_ff || rsp_ch.ready;
   assign cur_digit        = bcd_ff[idx_ff];
   assign idx_zero         = (idx_ff == '0);

   assign rsp_ch.valid     = out_valid_ff;
   assign rsp_ch.text_char = out_char_ff;
   assign rsp_ch.last_char = out_last_ff;

   assign stat.accept    = accept;
   assign stat.bits_done = (bitcnt_ff == BIT_CNT_W'(VALUE_W - 1));
   assign stat.scan_done = sticky_ff || (cur_digit != 4'd0) || idx_zero;
   assign stat.sign_done = !neg_ff || out_free;
   assign stat.last_done = out_free && idx_zero;

   always_comb begin
      for (int i = 0; i < MAX_DIGITS; i++) begin
         adj[i] = (bcd_ff[i] >= DIGIT_ADJ_MIN) ? (bcd_ff[i] + DIGIT_ADJ) : bcd_ff[i];
      end
   end

   always_comb begin
      mag_in       = mag_ff;
      neg_in       = neg_ff;
      bitcnt_in    = bitcnt_ff;
      bcd_in       = bcd_ff;
      sticky_in    = sticky_ff;
      idx_in       = idx_ff;
      out_valid_in = out_valid_ff && !rsp_ch.ready;
      out_char_in  = out_char_ff;
      out_last_in  = out_last_ff;

      if (accept) begin
         neg_in    = raw[VALUE_W-1];
         mag_in    = raw[VALUE_W-1] ? (~raw + VALUE_W'(1)) : raw;
         bitcnt_in = '0;
         sticky_in = 1'b0;
         idx_in    = TOP_IDX;
         for (int i = 0; i < MAX_DIGITS; i++) begin
            bcd_in[i] = 4'd0;
         end
      end

      if (ctrl.shift_en) begin
         mag_in    = {mag_ff[VALUE_W-2:0], 1'b0};
         bitcnt_in = bitcnt_ff + BIT_CNT_W'(1);
         // A bit leaving the top digit means the value has more digits than the store holds.
         sticky_in = sticky_ff || adj[MAX_DIGITS-1][3];
         for (int i = 0; i < MAX_DIGITS; i++) begin
            if (i == 0) begin
               bcd_in[i] = {adj[i][2:0], mag_ff[VALUE_W-1]};
            end else begin
               bcd_in[i] = {adj[i][2:0], adj[i-1][3]};
            end
         end
      end

      if (ctrl.scan_en && !stat.scan_done) begin
         idx_in = idx_ff - IDX_W'(1);
      end

      if (ctrl.sign_en && neg_ff && out_free) begin
         out_valid_in = 1'b1;
         out_char_in  = CHAR_MINUS;
         out_last_in  = 1'b0;
      end

      if (ctrl.digit_en && out_free) begin
         out_valid_in = 1'b1;
         out_char_in  = CHAR_ZERO + {4'd0, cur_digit};
         out_last_in  = idx_zero;
         if (!idx_zero) begin
            idx_in = idx_ff - IDX_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff      <= mag_in;
      neg_ff      <= neg_in;
      bitcnt_ff   <= bitcnt_in;
      bcd_ff      <= bcd_in;
      sticky_ff   <= sticky_in;
      idx_ff      <= idx_in;
      out_char_ff <= out_char_in;
      out_last_ff <= out_last_in;
   end

endmodule

FILE: src/signed_binary_to_decimal_ascii.sv
// Channel  Direction  Payload                       Handshake
// req_ch   in         value (signed 64-bit)         valid / ready
// rsp_ch   out        text_char (8-bit), last_char  valid / ready
//
// An item passes through an accept step, a shift-and-add-3 pass over the 64-bit
// magnitude, the leading-digit scan, the sign step and the emitted digits, which share
// the walk down the digit store with the scan.
// Reset is synchronous and active high; it clears the step counter and the output valid.
// A stall on rsp_ch holds the sequencer in its sign or digit step. The next item is
// accepted while the final character still waits in the output register.
module signed_binary_to_decimal_ascii #(
   parameter int unsigned MAX_DIGITS = b2d_pkg::DEF_MAX_DIGITS
) (
   input  logic       clock,
   input  logic       reset,
   b2d_req_if.sink    req_ch,
   b2d_rsp_if.source  rsp_ch
);
   import b2d_pkg::*;

   // The sequencer walks a five-step program: accept, convert, find the leading
   // digit, emit the sign and emit the digits. Each control word enables one part of
   // the datapath, and the datapath reports the flags that the jumps test.
   ctrl_type ctrl;
   stat_type stat;

   b2d_ucode u_ucode (
      .clock (clock),
      .reset (reset),
      .stat  (stat),
      .ctrl  (ctrl)
   );

   // The datapath holds the magnitude shift register, the BCD digit store sized by
   // MAX_DIGITS, the bit counter, the digit index and the output register.
   b2d_datapath #(
      .MAX_DIGITS (MAX_DIGITS)
   ) u_datapath (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (ctrl),
      .stat   (stat),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   // An accepted item always starts the conversion loop in the next cycle.
   a_accept_starts_shift: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready) |=> ctrl.shift_en)
      else $error("conversion did not start after an accepted item");

   // No character is produced while the conversion loop runs.
   a_no_output_in_shift: assert property (@(posedge clock) disable iff (reset)
      (ctrl.shift_en && !rsp_ch.valid) |=> !rsp_ch.valid)
      else $error("character produced during conversion");

   // Every character is a minus sign or a decimal digit.
   a_char_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> (rsp_ch.text_char == CHAR_MINUS)
                    || ((rsp_ch.text_char >= CHAR_ZERO) && (rsp_ch.text_char <= CHAR_NINE)))
      else $error("illegal character");

   // The sign never ends an item's text.
   a_minus_not_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && (rsp_ch.text_char == CHAR_MINUS)) |-> !rsp_ch.last_char)
      else $error("minus sign flagged as last character");

endmodule
